### sv/swrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swrd_pkg
// Shared types and constants for the switch route decision pipeline.
// ----------------------------------------------------------------------------
package swrd_pkg;

	localparam int LINKS           = 8;
	localparam int ID_BITS         = 16;
	localparam int SWITCH_CTRL_NUM = 194;

	localparam int LINK_W  = 3;
	localparam int DIR_W   = 4;
	localparam int CB_W    = 5;
	localparam int CCNT_W  = 9;
	localparam int RES_W   = 8;
	localparam int CFG_W   = 64;
	localparam int CIDX_W  = 3;
	localparam int DTAB_N  = 16;
	localparam int DTAB_IW = 4;
	localparam int POS_W   = 4;

	typedef enum logic [2:0] {
		ROUTE_LOCAL   = 3'd0,
		ROUTE_CTRL    = 3'd1,
		ROUTE_FORWARD = 3'd2,
		ROUTE_NO_LINK = 3'd3,
		ROUTE_BAD_CORE = 3'd4
	} route_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_NODE_ID       = 3'd0,
		REG_CORE_BITS     = 3'd1,
		REG_CORE_COUNT    = 3'd2,
		REG_DIR_TABLE     = 3'd3,
		REG_LINK_ENABLE   = 3'd4,
		REG_LINK_DIR_MAP  = 3'd5,
		REG_LINK_CONN     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                differ;
		logic                ctrl;
		logic                core_ok;
		logic [ID_BITS-1:0]  core;
		logic [DIR_W-1:0]    dir;
	} mid_t;

endpackage

`default_nettype wire

### sv/switch_route_decision.sv
`default_nettype none
// ----------------------------------------------------------------------------
// switch_route_decision
// Routing decision for one message header per cycle unless stalled: forward,
// local, control, or drop.
// ----------------------------------------------------------------------------
// Three-stage pipeline: stage 1 splits the destination into node and core
// parts and compares with the node id, stage 2 finds the highest differing
// node bit and looks up its direction, stage 3 picks the lowest enabled link
// with that direction and holds the result word. One word is accepted per
// cycle while in_stall is low; out_valid rises once it has passed the stage 1,
// 2 and 3 registers. Stall moves back through the stages so no word is lost
// or repeated. Configuration is written through cfg_write/cfg_index/cfg_data,
// only while the pipeline is empty: a rule for the user, not enforced here.
// ----------------------------------------------------------------------------
module switch_route_decision (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [swrd_pkg::CIDX_W-1:0]         cfg_index,
	input  wire logic [swrd_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [swrd_pkg::ID_BITS-1:0]        dest_node,
	input  wire logic                                is_config,
	input  wire logic [swrd_pkg::RES_W-1:0]          resource_num,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [2:0]                               route,
	output logic [swrd_pkg::LINK_W-1:0]              link_index,
	output logic [swrd_pkg::ID_BITS-1:0]             core_index,
	output logic [swrd_pkg::DIR_W-1:0]               direction
);

	logic [swrd_pkg::ID_BITS-1:0]              node_id_q;
	logic [swrd_pkg::CB_W-1:0]                 core_bits_q;
	logic [swrd_pkg::CCNT_W-1:0]               core_count_q;
	logic [swrd_pkg::DTAB_N*swrd_pkg::DIR_W-1:0] dir_table_q;
	logic [swrd_pkg::LINKS-1:0]                link_en_q;
	logic [swrd_pkg::LINKS*swrd_pkg::DIR_W-1:0] link_dir_q;
	logic [swrd_pkg::LINKS-1:0]                link_conn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q    <= '0;
			core_bits_q  <= '0;
			core_count_q <= '0;
			dir_table_q  <= '0;
			link_en_q    <= '0;
			link_dir_q   <= '0;
			link_conn_q  <= '0;
		end else if (cfg_write) begin
			unique case (swrd_pkg::cfg_reg_t'(cfg_index))
				swrd_pkg::REG_NODE_ID:      node_id_q    <= cfg_data[swrd_pkg::ID_BITS-1:0];
				swrd_pkg::REG_CORE_BITS:    core_bits_q  <= cfg_data[swrd_pkg::CB_W-1:0];
				swrd_pkg::REG_CORE_COUNT:   core_count_q <= cfg_data[swrd_pkg::CCNT_W-1:0];
				swrd_pkg::REG_DIR_TABLE:    dir_table_q  <= cfg_data;
				swrd_pkg::REG_LINK_ENABLE:  link_en_q    <= cfg_data[swrd_pkg::LINKS-1:0];
				swrd_pkg::REG_LINK_DIR_MAP:
					link_dir_q <= cfg_data[swrd_pkg::LINKS*swrd_pkg::DIR_W-1:0];
				swrd_pkg::REG_LINK_CONN:    link_conn_q  <= cfg_data[swrd_pkg::LINKS-1:0];
				default: ;
			endcase
		end
	end

	// flow control
	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: split and compare
	logic [swrd_pkg::CB_W-1:0]    cb;
	logic [swrd_pkg::ID_BITS-1:0] dnode;
	logic [swrd_pkg::ID_BITS:0]   core_mask;
	logic [swrd_pkg::ID_BITS-1:0] core_c;

	assign cb        = (core_bits_q > swrd_pkg::CB_W'(swrd_pkg::ID_BITS)) ?
	                   swrd_pkg::CB_W'(swrd_pkg::ID_BITS) : core_bits_q;
	assign dnode     = dest_node >> cb;
	assign core_mask = (swrd_pkg::ID_BITS+1)'((swrd_pkg::ID_BITS+1)'(1) << cb) -
	                   (swrd_pkg::ID_BITS+1)'(1);
	assign core_c    = dest_node & core_mask[swrd_pkg::ID_BITS-1:0];

	logic [swrd_pkg::ID_BITS-1:0] diff_s1;
	logic [swrd_pkg::ID_BITS-1:0] core_s1;
	logic                         ctrl_s1;
	logic                         core_ok_s1;
	logic [swrd_pkg::DTAB_IW-1:0] cb_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			diff_s1    <= dnode ^ node_id_q;
			core_s1    <= core_c;
			ctrl_s1    <= is_config &&
			              (resource_num == swrd_pkg::RES_W'(swrd_pkg::SWITCH_CTRL_NUM));
			core_ok_s1 <= {{(32-swrd_pkg::ID_BITS){1'b0}}, core_c} <
			              {{(32-swrd_pkg::CCNT_W){1'b0}}, core_count_q};
			cb_s1      <= cb[swrd_pkg::DTAB_IW-1:0];
		end
	end

	// stage 2: highest differing bit and direction lookup
	logic [swrd_pkg::POS_W-1:0]    top_pos;
	logic [swrd_pkg::DTAB_IW-1:0]  tab_idx;
	logic [swrd_pkg::DIR_W-1:0]    dir_lu;

	always_comb begin
		top_pos = '0;
		for (int i = 0; i < swrd_pkg::ID_BITS; i++) begin
			if (diff_s1[i]) top_pos = swrd_pkg::POS_W'(i);
		end
	end

	assign tab_idx = swrd_pkg::DTAB_IW'(swrd_pkg::DTAB_IW'(swrd_pkg::ID_BITS - 1) -
	                 cb_s1 - top_pos);
	assign dir_lu  = dir_table_q[tab_idx*swrd_pkg::DIR_W +: swrd_pkg::DIR_W];

	swrd_pkg::mid_t mid_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			mid_s2.differ  <= |diff_s1;
			mid_s2.ctrl    <= ctrl_s1;
			mid_s2.core_ok <= core_ok_s1;
			mid_s2.core    <= core_s1;
			mid_s2.dir     <= dir_lu;
		end
	end

	// stage 3: link select and result word
	logic                         found;
	logic [swrd_pkg::LINK_W-1:0]  sel_link;
	swrd_pkg::route_t             route_n;
	logic [swrd_pkg::LINK_W-1:0]  link_n;
	logic [swrd_pkg::ID_BITS-1:0] core_n;
	logic [swrd_pkg::DIR_W-1:0]   dir_n;

	always_comb begin
		found    = 1'b0;
		sel_link = '0;
		for (int l = swrd_pkg::LINKS - 1; l >= 0; l--) begin
			if (link_en_q[l] &&
			    link_dir_q[l*swrd_pkg::DIR_W +: swrd_pkg::DIR_W] == mid_s2.dir) begin
				found    = 1'b1;
				sel_link = swrd_pkg::LINK_W'(l);
			end
		end
	end

	always_comb begin
		route_n = swrd_pkg::ROUTE_LOCAL;
		link_n  = '0;
		core_n  = '0;
		dir_n   = '0;
		priority if (mid_s2.differ) begin
			dir_n = mid_s2.dir;
			if (found && link_conn_q[sel_link]) begin
				route_n = swrd_pkg::ROUTE_FORWARD;
				link_n  = sel_link;
			end else begin
				route_n = swrd_pkg::ROUTE_NO_LINK;
			end
		end else if (mid_s2.ctrl) begin
			route_n = swrd_pkg::ROUTE_CTRL;
		end else if (!mid_s2.core_ok) begin
			route_n = swrd_pkg::ROUTE_BAD_CORE;
		end else begin
			route_n = swrd_pkg::ROUTE_LOCAL;
			core_n  = mid_s2.core;
		end
	end

	swrd_pkg::route_t             route_s3;
	logic [swrd_pkg::LINK_W-1:0]  link_s3;
	logic [swrd_pkg::ID_BITS-1:0] core_s3;
	logic [swrd_pkg::DIR_W-1:0]   dir_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			route_s3 <= route_n;
			link_s3  <= link_n;
			core_s3  <= core_n;
			dir_s3   <= dir_n;
		end
	end

	assign out_valid  = valid_s3;
	assign route      = route_s3;
	assign link_index = link_s3;
	assign core_index = core_s3;
	assign direction  = dir_s3;

endmodule

`default_nettype wire

### test/tb_switch_route_decision.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_switch_route_decision
// Checks the switch route decision block against a predictor of its routing
// rules: node compare above the core bits, direction lookup for the highest
// differing bit, lowest enabled link, control delivery and local core range.
// Directed words cover each route and corner; random phases rerun the block
// under many register settings with random idling, a long output hold-off
// and a stretch with no idling at all.
// ----------------------------------------------------------------------------
module tb_switch_route_decision;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_IDLE      = 12;

	typedef struct {
		logic [15:0] node_id;
		logic [4:0]  core_bits;
		logic [8:0]  core_count;
		logic [63:0] dir_table;
		logic [7:0]  link_enable;
		logic [31:0] link_dir_map;
		logic [7:0]  link_conn;
	} switch_cfg_t;

	typedef struct {
		swrd_pkg::route_t route;
		logic [2:0]       link;
		logic [15:0]      core;
		logic [3:0]       dir;
	} route_word_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write;
	swrd_pkg::cfg_reg_t cfg_index;
	logic [63:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [15:0]        dest_node;
	logic               is_config;
	logic [7:0]         resource_num;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         route;
	logic [2:0]         link_index;
	logic [15:0]        core_index;
	logic [3:0]         direction;

	switch_cfg_t sw_cfg;
	route_word_t pending_routes[$];
	int          mismatches = 0;
	int          words_sent = 0;
	int          results_checked = 0;
	int          reg_writes = 0;
	int          route_seen[5] = '{default: 0};
	int          cycle_count = 0;
	int          hold_cycles = 0;
	bit          send_quiet = 0;
	bit          recv_quiet = 0;

	switch_route_decision DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.dest_node    (dest_node),
		.is_config    (is_config),
		.resource_num (resource_num),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.route        (route),
		.link_index   (link_index),
		.core_index   (core_index),
		.direction    (direction)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic route_word_t decide_route(input logic [15:0] dest, input logic is_cfg,
			input logic [7:0] res);
		route_word_t r;
		int          cb;
		int          top;
		int          idx;
		int          sel;
		int          i;
		bit          found;
		logic [31:0] node_part;
		logic [31:0] differ;
		logic [31:0] core_sel;
		r.route = swrd_pkg::ROUTE_LOCAL;
		r.link = '0;
		r.core = '0;
		r.dir = '0;
		cb = (sw_cfg.core_bits > 5'd16) ? 16 : int'(sw_cfg.core_bits);
		node_part = {16'd0, dest} >> cb;
		differ = node_part ^ {16'd0, sw_cfg.node_id};
		if (differ != 32'd0) begin
			top = 0;
			for (i = 0; i < 32; i++)
				if (differ[i])
					top = i;
			idx = (15 - cb - top) & 15;
			r.dir = sw_cfg.dir_table[4*idx +: 4];
			found = 0;
			sel = 0;
			for (i = swrd_pkg::LINKS - 1; i >= 0; i--)
				if (sw_cfg.link_enable[i] && sw_cfg.link_dir_map[4*i +: 4] == r.dir) begin
					found = 1;
					sel = i;
				end
			if (found && sw_cfg.link_conn[sel]) begin
				r.route = swrd_pkg::ROUTE_FORWARD;
				r.link = 3'(sel);
			end else begin
				r.route = swrd_pkg::ROUTE_NO_LINK;
			end
		end else if (is_cfg && res == 8'(swrd_pkg::SWITCH_CTRL_NUM)) begin
			r.route = swrd_pkg::ROUTE_CTRL;
		end else begin
			core_sel = {16'd0, dest} & ((32'd1 << cb) - 32'd1);
			if (core_sel >= {23'd0, sw_cfg.core_count}) begin
				r.route = swrd_pkg::ROUTE_BAD_CORE;
			end else begin
				r.route = swrd_pkg::ROUTE_LOCAL;
				r.core = core_sel[15:0];
			end
		end
		return r;
	endfunction

	task automatic write_reg(input swrd_pkg::cfg_reg_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			swrd_pkg::REG_NODE_ID:      sw_cfg.node_id = value[15:0];
			swrd_pkg::REG_CORE_BITS:    sw_cfg.core_bits = value[4:0];
			swrd_pkg::REG_CORE_COUNT:   sw_cfg.core_count = value[8:0];
			swrd_pkg::REG_DIR_TABLE:    sw_cfg.dir_table = value;
			swrd_pkg::REG_LINK_ENABLE:  sw_cfg.link_enable = value[7:0];
			swrd_pkg::REG_LINK_DIR_MAP: sw_cfg.link_dir_map = value[31:0];
			swrd_pkg::REG_LINK_CONN:    sw_cfg.link_conn = value[7:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic write_all_regs(input logic [15:0] nid, input logic [4:0] cb,
			input logic [8:0] cc, input logic [63:0] dt, input logic [7:0] en,
			input logic [31:0] lm, input logic [7:0] conn);
		write_reg(swrd_pkg::REG_NODE_ID, 64'(nid));
		write_reg(swrd_pkg::REG_CORE_BITS, 64'(cb));
		write_reg(swrd_pkg::REG_CORE_COUNT, 64'(cc));
		write_reg(swrd_pkg::REG_DIR_TABLE, dt);
		write_reg(swrd_pkg::REG_LINK_ENABLE, 64'(en));
		write_reg(swrd_pkg::REG_LINK_DIR_MAP, 64'(lm));
		write_reg(swrd_pkg::REG_LINK_CONN, 64'(conn));
	endtask

	task automatic send_word(input logic [15:0] dest, input logic is_cfg, input logic [7:0] res);
		int          gap;
		route_word_t want;
		gap = send_quiet ? 0 : $urandom_range(0, MAX_IDLE);
		want = decide_route(dest, is_cfg, res);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		dest_node <= dest;
		is_config <= is_cfg;
		resource_num <= res;
		do @(posedge clk); while (in_stall);
		pending_routes = {pending_routes, want};
		words_sent++;
	endtask

	// drop valid, let every expected word arrive, then let the pipeline settle
	task automatic wait_idle;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_routes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_word;
		int          cb;
		int          kind;
		logic [15:0] dest;
		logic [7:0]  res;
		cb = (sw_cfg.core_bits > 5'd16) ? 16 : int'(sw_cfg.core_bits);
		kind = $urandom_range(0, 9);
		dest = 16'($urandom);
		if (kind < 6)
			dest = 16'(({16'd0, sw_cfg.node_id} << cb) |
				({16'd0, dest} & ((32'd1 << cb) - 32'd1)));
		if (kind >= 4 && kind < 6)
			dest = dest ^ (16'd1 << $urandom_range(0, 15));
		res = ($urandom_range(0, 2) == 0) ? 8'(swrd_pkg::SWITCH_CTRL_NUM) : 8'($urandom);
		send_word(dest, 1'($urandom), res);
	endtask

	task automatic randomize_switch_config;
		logic [4:0]  cb;
		int          cb_eff;
		logic [15:0] nid;
		logic [8:0]  cc;
		logic [63:0] dt;
		logic [31:0] lm;
		cb = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
		cb_eff = (cb > 5'd16) ? 16 : int'(cb);
		nid = 16'($urandom);
		if ($urandom_range(0, 3) != 0)
			nid = nid >> cb_eff;
		case ($urandom_range(0, 3))
			0: cc = 9'($urandom_range(0, 256));
			1: cc = 9'($urandom_range(0, (cb_eff >= 9) ? 511 : (1 << cb_eff)));
			2: cc = 9'd256;
			default: cc = 9'($urandom_range(0, 511));
		endcase
		dt = {$urandom, $urandom};
		lm = $urandom;
		// narrow the direction codes so that links match often
		if ($urandom_range(0, 2) != 0) begin
			dt = dt & 64'h3333_3333_3333_3333;
			lm = lm & 32'h3333_3333;
		end
		write_all_regs(nid, cb, cc, dt, 8'($urandom), lm, 8'($urandom));
	endtask

	task automatic test_reset_state;
		send_word(16'h0000, 1'b1, 8'(swrd_pkg::SWITCH_CTRL_NUM));
		send_word(16'h0000, 1'b0, 8'h00);
		send_word(16'hFFFF, 1'b1, 8'hFF);
		send_word(16'h8000, 1'b0, 8'(swrd_pkg::SWITCH_CTRL_NUM));
		wait_idle();
	endtask

	task automatic test_directed_routes;
		write_all_regs(16'h0123, 5'd4, 9'd6, 64'hFEDC_BA98_7654_3210, 8'b1011_1111,
			32'h7652_3210, 8'b1111_1011);
		send_word(16'h1230, 1'b0, 8'h00);
		send_word(16'h1235, 1'b0, 8'h00);
		send_word(16'h1236, 1'b0, 8'h00);
		send_word(16'h123F, 1'b1, 8'hFF);
		send_word(16'h1237, 1'b1, 8'(swrd_pkg::SWITCH_CTRL_NUM));
		send_word(16'h1231, 1'b1, 8'(swrd_pkg::SWITCH_CTRL_NUM - 1));
		send_word(16'h1232, 1'b0, 8'(swrd_pkg::SWITCH_CTRL_NUM));
		send_word(16'h9230, 1'b1, 8'(swrd_pkg::SWITCH_CTRL_NUM));
		send_word(16'h3230, 1'b0, 8'h00);
		send_word(16'h0230, 1'b0, 8'h00);
		send_word(16'h1030, 1'b0, 8'h00);
		send_word(16'h1220, 1'b0, 8'h00);
		send_word(16'hFFFF, 1'b1, 8'hFF);
		send_word(16'h0000, 1'b0, 8'h00);
		wait_idle();
		// node id wider than the node part
		write_reg(swrd_pkg::REG_NODE_ID, 64'h0000_0000_0000_F123);
		send_word(16'h1230, 1'b0, 8'h00);
		wait_idle();
		// oversized core field
		write_reg(swrd_pkg::REG_NODE_ID, 64'd0);
		write_reg(swrd_pkg::REG_CORE_BITS, 64'd20);
		write_reg(swrd_pkg::REG_CORE_COUNT, 64'd511);
		send_word(16'hABCD, 1'b0, 8'h00);
		send_word(16'h01FE, 1'b0, 8'h00);
		send_word(16'h0000, 1'b1, 8'(swrd_pkg::SWITCH_CTRL_NUM));
		wait_idle();
		write_reg(swrd_pkg::REG_CORE_BITS, 64'd0);
		send_word(16'h0000, 1'b0, 8'h00);
		send_word(16'h8000, 1'b0, 8'h00);
		wait_idle();
	endtask

	task automatic test_config_extremes;
		write_all_regs(16'hFFFF, 5'h1F, 9'h1FF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
			8'hFF);
		send_word(16'hFFFF, 1'b1, 8'hFF);
		send_word(16'h0000, 1'b0, 8'h00);
		wait_idle();
		write_all_regs(16'h0000, 5'd16, 9'd256, 64'd0, 8'h00, 32'd0, 8'h00);
		send_word(16'hFFFF, 1'b1, 8'(swrd_pkg::SWITCH_CTRL_NUM));
		send_word(16'h00FF, 1'b0, 8'h00);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int phases, input int words_per_phase);
		int p;
		for (p = 0; p < phases; p++) begin
			randomize_switch_config();
			repeat (words_per_phase) send_random_word();
			wait_idle();
		end
	endtask

	task automatic test_back_pressure;
		randomize_switch_config();
		send_quiet = 1;
		hold_cycles = 60;
		repeat (24) send_random_word();
		send_quiet = 0;
		wait_idle();
	endtask

	task automatic test_steady_stream;
		randomize_switch_config();
		send_quiet = 1;
		recv_quiet = 1;
		repeat (40) send_random_word();
		wait_idle();
		send_quiet = 0;
		recv_quiet = 0;
	endtask

	// result sink: random stall before each word, long hold-off on request
	initial begin : result_sink
		int gap;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (hold_cycles - 1) @(negedge clk);
				hold_cycles = 0;
			end
			gap = recv_quiet ? 0 : $urandom_range(0, MAX_IDLE);
			if (gap > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		route_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_routes.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected word: route %0d link %0d core %0d dir %0d",
						route, link_index, core_index, direction);
				mismatches++;
			end else begin
				want = pending_routes.pop_front();
				route_seen[int'(want.route)]++;
				if (route !== want.route || link_index !== want.link ||
						core_index !== want.core || direction !== want.dir) begin
					if (mismatches < 10)
						$display("word %0d: expected route %0d link %0d core %0d dir %0d, %s %0d %0d %0d %0d",
							results_checked, want.route, want.link, want.core, want.dir,
							"got", route, link_index, core_index, direction);
					mismatches++;
				end
				results_checked++;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = swrd_pkg::REG_NODE_ID;
		cfg_data = '0;
		in_valid = 1'b0;
		dest_node = '0;
		is_config = 1'b0;
		resource_num = '0;
		sw_cfg = '{default: '0};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed_routes();
		test_config_extremes();
		test_random_traffic(6, 65);
		test_back_pressure();
		test_steady_stream();

		mismatches += pending_routes.size();
		$display("covered %0d header words and %0d register writes, %0d results checked",
			words_sent, reg_writes, results_checked);
		$display("routes seen: local %0d, control %0d, forward %0d, no link %0d, bad core %0d",
			route_seen[0], route_seen[1], route_seen[2], route_seen[3], route_seen[4]);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
